// ===== design/gha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_pkg: shared types and constants of the generational handle allocator
// Holds the slot count, the operation and status codes, the transfer payload
// structs, the slot memory entry layout and the sequencer state type.
// ----------------------------------------------------------------------------
package gha_pkg;

   // Table geometry.
   localparam int SLOT_COUNT = 1024;
   localparam int IDX_W      = $clog2(SLOT_COUNT);
   localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
   localparam int VER_W      = 8;

   localparam logic [CNT_W-1:0] LIST_EMPTY = CNT_W'(SLOT_COUNT);
   localparam logic [VER_W-1:0] VER_FIRST  = VER_W'(1);

   // Operation codes.
   localparam logic [1:0] OP_CREATE  = 2'd0;
   localparam logic [1:0] OP_DESTROY = 2'd1;
   localparam logic [1:0] OP_QUERY   = 2'd2;

   // Status codes.
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_DEAD = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic [1:0]       op;
      logic [IDX_W-1:0] handle_index;
      logic [VER_W-1:0] handle_version;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [IDX_W-1:0] out_index;
      logic [VER_W-1:0] out_version;
      logic             is_live;
      logic [CNT_W-1:0] live_count;
   } rsp_type;

   // One slot of the table: live flag, version and free-list link.
   typedef struct packed {
      logic             live;
      logic [VER_W-1:0] version;
      logic [CNT_W-1:0] next_free;
   } entry_type;

   // Everything the update logic hands back to the sequencer.
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
      logic [CNT_W-1:0] free_head;
      logic [CNT_W-1:0] slots_used;
      logic [CNT_W-1:0] live_total;
      rsp_type          rsp;
   } update_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage

// ===== design/generational_handle_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_handle_allocator_top: versioned slot handle allocator
// Creates, destroys and checks handles made of a slot index and a version,
// with a LIFO free list threaded through the slot table.
//
//   Channel   Ports                        Transfer
//   request   start, busy, req_data        start high while busy is low
//   response  rsp_strobe, rsp_data         one cycle with rsp_strobe high
//
// Each operation reads the slot memory in its accept cycle; the next cycle
// writes it back and updates the list head and counters.
// The response appears in the cycle after that, while the next request may
// already be accepted; none is accepted in the execute cycle (busy high).
// Reset clears the state, response strobe, list head and counters; the slot
// memory needs no clearing pass. The response side cannot stall.
// ----------------------------------------------------------------------------
module generational_handle_allocator_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  gha_pkg::req_type req_data,
   output logic             rsp_strobe,
   output gha_pkg::rsp_type rsp_data
);

   gha_pkg::state_type          state_ff, state_in;
   gha_pkg::req_type            req_ff;
   logic [gha_pkg::CNT_W-1:0]   free_head_ff, free_head_in;
   logic [gha_pkg::CNT_W-1:0]   slots_used_ff, slots_used_in;
   logic [gha_pkg::CNT_W-1:0]   live_total_ff, live_total_in;
   logic                        rsp_strobe_ff, rsp_strobe_in;
   gha_pkg::rsp_type            rsp_data_ff;

   logic                        accept;
   logic                        exec;
   logic [gha_pkg::IDX_W-1:0]   rd_addr;
   gha_pkg::entry_type          rd_data;
   gha_pkg::update_type         upd;

   assign accept = start && !busy;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gha_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = gha_pkg::ST_EXEC;
            end
         end
         gha_pkg::ST_EXEC: begin
            state_in = gha_pkg::ST_IDLE;
         end
         default: begin
            state_in = gha_pkg::ST_IDLE;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      busy = 1'b0;
      exec = 1'b0;
      case (state_ff)
         gha_pkg::ST_IDLE: begin
            busy = 1'b0;
         end
         gha_pkg::ST_EXEC: begin
            busy = 1'b1;
            exec = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   // Creates read the list head; other operations read the named slot.
   assign rd_addr = (req_data.op == gha_pkg::OP_CREATE) ?
                    free_head_ff[gha_pkg::IDX_W-1:0] : req_data.handle_index;

   gha_slot_ram u_slot_ram (
      .clock   (clock),
      .wr_en   (upd.wr_en && exec),
      .wr_addr (upd.wr_addr),
      .wr_data (upd.wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   gha_update u_update (
      .req        (req_ff),
      .entry      (rd_data),
      .free_head  (free_head_ff),
      .slots_used (slots_used_ff),
      .live_total (live_total_ff),
      .upd        (upd)
   );

   // Bookkeeping updates land at the end of the execute cycle.
   always_comb begin
      free_head_in  = exec ? upd.free_head  : free_head_ff;
      slots_used_in = exec ? upd.slots_used : slots_used_ff;
      live_total_in = exec ? upd.live_total : live_total_ff;
      rsp_strobe_in = exec;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= gha_pkg::ST_IDLE;
         free_head_ff  <= gha_pkg::LIST_EMPTY;
         slots_used_ff <= '0;
         live_total_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_head_ff  <= free_head_in;
         slots_used_ff <= slots_used_in;
         live_total_ff <= live_total_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers: captured request and outgoing response.
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (exec) begin
         rsp_data_ff <= upd.rsp;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ===== design/gha_slot_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_slot_ram: slot table storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gha_slot_ram (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [gha_pkg::IDX_W-1:0] wr_addr,
   input  gha_pkg::entry_type       wr_data,
   input  logic                     rd_en,
   input  logic [gha_pkg::IDX_W-1:0] rd_addr,
   output gha_pkg::entry_type       rd_data
);

   gha_pkg::entry_type mem [gha_pkg::SLOT_COUNT];
   gha_pkg::entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/gha_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_update: read-modify-write decision for one operation
// From the slot entry just read and the bookkeeping registers, works out the
// slot write-back, the new bookkeeping values and the result.
// ----------------------------------------------------------------------------
module gha_update (
   input  gha_pkg::req_type              req,
   input  gha_pkg::entry_type            entry,
   input  logic [gha_pkg::CNT_W-1:0]     free_head,
   input  logic [gha_pkg::CNT_W-1:0]     slots_used,
   input  logic [gha_pkg::CNT_W-1:0]     live_total,
   output gha_pkg::update_type           upd
);

   logic                         handle_live;
   logic                         list_has_slot;
   logic                         fresh_left;
   logic [gha_pkg::VER_W-1:0]    bumped_ver;
   logic [gha_pkg::CNT_W-1:0]    next_head;

   // Liveness of the given handle; entries at or above slots_used were never written.
   assign handle_live = ({1'b0, req.handle_index} < slots_used) && entry.live
                        && (entry.version == req.handle_version);

   assign list_has_slot = free_head < gha_pkg::LIST_EMPTY;
   assign fresh_left    = slots_used < gha_pkg::LIST_EMPTY;

   // Next version of a reused slot, skipping zero.
   always_comb begin
      bumped_ver = entry.version + gha_pkg::VER_FIRST;
      if (bumped_ver == '0) begin
         bumped_ver = gha_pkg::VER_FIRST;
      end
   end

   // Link read from the list head, clamped to the empty marker.
   assign next_head = (entry.next_free > gha_pkg::LIST_EMPTY) ? gha_pkg::LIST_EMPTY
                                                               : entry.next_free;

   always_comb begin
      upd                     = '0;
      upd.wr_en               = 1'b0;
      upd.wr_addr             = req.handle_index;
      upd.wr_data             = entry;
      upd.free_head           = free_head;
      upd.slots_used          = slots_used;
      upd.live_total          = live_total;
      upd.rsp.status          = gha_pkg::STATUS_OK;
      upd.rsp.out_index       = req.handle_index;
      upd.rsp.out_version     = req.handle_version;
      upd.rsp.is_live         = 1'b0;

      case (req.op)
         gha_pkg::OP_CREATE: begin
            if (list_has_slot) begin
               // Reuse the head of the free list.
               upd.wr_en               = 1'b1;
               upd.wr_addr             = free_head[gha_pkg::IDX_W-1:0];
               upd.wr_data.live        = 1'b1;
               upd.wr_data.version     = bumped_ver;
               upd.free_head           = next_head;
               upd.live_total          = live_total + 1'b1;
               upd.rsp.out_index       = free_head[gha_pkg::IDX_W-1:0];
               upd.rsp.out_version     = bumped_ver;
            end else if (fresh_left) begin
               // Hand out a slot that was never used.
               upd.wr_en               = 1'b1;
               upd.wr_addr             = slots_used[gha_pkg::IDX_W-1:0];
               upd.wr_data.live        = 1'b1;
               upd.wr_data.version     = gha_pkg::VER_FIRST;
               upd.wr_data.next_free   = gha_pkg::LIST_EMPTY;
               upd.slots_used          = slots_used + 1'b1;
               upd.live_total          = live_total + 1'b1;
               upd.rsp.out_index       = slots_used[gha_pkg::IDX_W-1:0];
               upd.rsp.out_version     = gha_pkg::VER_FIRST;
            end else begin
               upd.rsp.status          = gha_pkg::STATUS_FULL;
            end
         end
         gha_pkg::OP_DESTROY: begin
            upd.rsp.is_live = handle_live;
            if (handle_live) begin
               // Free the slot and push it on the list.
               upd.wr_en               = 1'b1;
               upd.wr_data.live        = 1'b0;
               upd.wr_data.next_free   = free_head;
               upd.free_head           = {1'b0, req.handle_index};
               if (live_total != '0) begin
                  upd.live_total = live_total - 1'b1;
               end
            end else begin
               upd.rsp.status = gha_pkg::STATUS_DEAD;
            end
         end
         default: begin
            // Query, and the unused code that behaves as one.
            upd.rsp.is_live = handle_live;
            upd.rsp.status  = handle_live ? gha_pkg::STATUS_OK : gha_pkg::STATUS_DEAD;
         end
      endcase

      upd.rsp.live_count = upd.live_total;
   end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the generational handle allocator
// Drives create, destroy and query requests through the start/busy command
// port, predicts every response with a behavioral copy of the slot table and
// free list, and compares each response strobe field by field in order.
// Covers the reset state, LIFO reuse, stale handles, version wraparound,
// random traffic under varying sender gaps and a completely full table.
// ----------------------------------------------------------------------------
module tb;

   localparam int QUIET_LIMIT  = 2000;
   localparam int REPORT_LIMIT = 10;
   localparam int RANDOM_ITEMS = 150;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   gha_pkg::req_type req_data;
   logic             rsp_strobe;
   gha_pkg::rsp_type rsp_data;

   // Predicted slot table, list head and counters.
   bit                        slot_is_live [gha_pkg::SLOT_COUNT];
   logic [gha_pkg::VER_W-1:0] slot_gen     [gha_pkg::SLOT_COUNT];
   logic [gha_pkg::CNT_W-1:0] slot_link    [gha_pkg::SLOT_COUNT];
   logic [gha_pkg::CNT_W-1:0] list_head;
   logic [gha_pkg::CNT_W-1:0] slots_issued;
   logic [gha_pkg::CNT_W-1:0] live_handles;

   gha_pkg::rsp_type pending_replies[$];
   int               mismatches;
   int               gap_pct;
   int               quiet_cycles;

   generational_handle_allocator_top DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Apply one request to the predicted table and return the expected response.
   function automatic gha_pkg::rsp_type apply_handle_op(input gha_pkg::req_type item);
      gha_pkg::rsp_type          res;
      logic [gha_pkg::CNT_W-1:0] slot;
      logic [gha_pkg::VER_W-1:0] next_gen;
      bit                        hit;
      res.status      = gha_pkg::STATUS_OK;
      res.out_index   = item.handle_index;
      res.out_version = item.handle_version;
      res.is_live     = 1'b0;
      hit = ({1'b0, item.handle_index} < slots_issued) &&
            slot_is_live[item.handle_index] &&
            (slot_gen[item.handle_index] == item.handle_version);
      if (item.op == gha_pkg::OP_CREATE) begin
         slot     = gha_pkg::LIST_EMPTY;
         next_gen = gha_pkg::VER_FIRST;
         if (list_head != gha_pkg::LIST_EMPTY) begin
            // Reuse the free-list head with the next nonzero version.
            slot     = list_head;
            next_gen = slot_gen[slot] + 1'b1;
            if (next_gen == '0) begin
               next_gen = gha_pkg::VER_FIRST;
            end
            list_head = slot_link[slot];
            if (list_head > gha_pkg::LIST_EMPTY) begin
               list_head = gha_pkg::LIST_EMPTY;
            end
         end else if (slots_issued != gha_pkg::LIST_EMPTY) begin
            slot            = slots_issued;
            slots_issued    = slots_issued + 1'b1;
            slot_link[slot] = gha_pkg::LIST_EMPTY;
         end
         if (slot != gha_pkg::LIST_EMPTY) begin
            slot_is_live[slot] = 1'b1;
            slot_gen[slot]     = next_gen;
            live_handles       = live_handles + 1'b1;
            res.out_index      = slot[gha_pkg::IDX_W-1:0];
            res.out_version    = next_gen;
         end else begin
            res.status = gha_pkg::STATUS_FULL;
         end
      end else if (item.op == gha_pkg::OP_DESTROY) begin
         res.is_live = hit;
         if (hit) begin
            // Free the slot and push it on the list.
            slot_is_live[item.handle_index] = 1'b0;
            slot_link[item.handle_index]    = list_head;
            list_head                       = {1'b0, item.handle_index};
            if (live_handles != '0) begin
               live_handles = live_handles - 1'b1;
            end
         end else begin
            res.status = gha_pkg::STATUS_DEAD;
         end
      end else begin
         // Query, and the unused code that behaves as one.
         res.is_live = hit;
         res.status  = hit ? gha_pkg::STATUS_OK : gha_pkg::STATUS_DEAD;
      end
      res.live_count = live_handles;
      return res;
   endfunction

   function automatic gha_pkg::req_type make_req(input logic [1:0] op, input int idx,
                                                 input int ver);
      gha_pkg::req_type item;
      item.op             = op;
      item.handle_index   = idx[gha_pkg::IDX_W-1:0];
      item.handle_version = ver[gha_pkg::VER_W-1:0];
      return item;
   endfunction

   // Send one request; the prediction is made at the edge that accepts it.
   task automatic send_request(input gha_pkg::req_type item,
                               output gha_pkg::rsp_type outcome);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      outcome = apply_handle_op(item);
      pending_replies = {pending_replies, outcome};
   endtask

   // Compare each response transfer with the oldest prediction.
   always @(posedge clock) begin
      gha_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("Unexpected response: status %0d index %0d version %0d",
                        rsp_data.status, rsp_data.out_index, rsp_data.out_version);
               $display("   live %0d count %0d", rsp_data.is_live, rsp_data.live_count);
            end
         end else begin
            want = pending_replies.pop_front();
            if (rsp_data.status !== want.status || rsp_data.out_index !== want.out_index ||
                rsp_data.out_version !== want.out_version ||
                rsp_data.is_live !== want.is_live ||
                rsp_data.live_count !== want.live_count) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("Response mismatch at %0t: expected %0d/%0d/%0d/%0d/%0d",
                           $realtime, want.status, want.out_index, want.out_version,
                           want.is_live, want.live_count);
                  $display("   actual status/index/version/live/count %0d/%0d/%0d/%0d/%0d",
                           rsp_data.status, rsp_data.out_index, rsp_data.out_version,
                           rsp_data.is_live, rsp_data.live_count);
               end
            end
         end
      end
   end

   // Watchdog: stop when no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Reset state, basic create/destroy/query, stale handles and LIFO reuse.
   task automatic test_directed();
      gha_pkg::rsp_type r;
      gap_pct = 18;
      send_request(make_req(gha_pkg::OP_QUERY, 1023, 255), r);
      send_request(make_req(gha_pkg::OP_DESTROY, 0, 0), r);
      send_request(make_req(gha_pkg::OP_CREATE, 1023, 255), r);
      send_request(make_req(gha_pkg::OP_CREATE, 0, 0), r);
      send_request(make_req(gha_pkg::OP_QUERY, 0, 1), r);
      send_request(make_req(gha_pkg::OP_QUERY, 0, 2), r);
      send_request(make_req(2'd3, 0, 1), r);
      send_request(make_req(gha_pkg::OP_DESTROY, 0, 1), r);
      send_request(make_req(gha_pkg::OP_DESTROY, 0, 1), r);
      send_request(make_req(gha_pkg::OP_QUERY, 0, 1), r);
      send_request(make_req(gha_pkg::OP_DESTROY, 1, 1), r);
      send_request(make_req(gha_pkg::OP_CREATE, 512, 128), r);
      send_request(make_req(gha_pkg::OP_CREATE, 0, 0), r);
      send_request(make_req(gha_pkg::OP_CREATE, 0, 0), r);
      send_request(make_req(2'd3, 2, 1), r);
      send_request(make_req(gha_pkg::OP_QUERY, 2, 0), r);
      send_request(make_req(gha_pkg::OP_DESTROY, 1023, 1), r);
      send_request(make_req(gha_pkg::OP_DESTROY, 5, 1), r);
      send_request(make_req(gha_pkg::OP_QUERY, 0, 0), r);
      send_request(make_req(gha_pkg::OP_DESTROY, 2, 1), r);
      send_request(make_req(gha_pkg::OP_QUERY, 2, 1), r);
   endtask

   // Recycle one slot until its version wraps from 255 back to 1.
   task automatic test_version_wrap();
      gha_pkg::rsp_type r;
      int               slot;
      int               ver;
      gap_pct = 18;
      send_request(make_req(gha_pkg::OP_CREATE, 0, 0), r);
      slot = r.out_index;
      ver  = r.out_version;
      repeat (260) begin
         send_request(make_req(gha_pkg::OP_DESTROY, slot, ver), r);
         send_request(make_req(gha_pkg::OP_CREATE, $urandom_range(1023),
                               $urandom_range(255)), r);
         slot = r.out_index;
         ver  = r.out_version;
      end
   endtask

   // Mostly well-formed traffic on issued slots, with stale handles and noise.
   task automatic test_random_traffic();
      gha_pkg::rsp_type r;
      int               roll;
      int               create_pct;
      int               idx;
      int               ver;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            gap_pct = 88;
         end else if (n == 2 * RANDOM_ITEMS / 3) begin
            gap_pct = 0;
         end else if (n == 0) begin
            gap_pct = 18;
         end
         create_pct = (live_handles < 40) ? 45 : 25;
         roll       = $urandom_range(99);
         idx        = (slots_issued == 0) ? 0 : $urandom_range(int'(slots_issued) - 1);
         ver        = ($urandom_range(99) < 80) ? int'(slot_gen[idx]) : $urandom_range(255);
         if (roll < create_pct) begin
            send_request(make_req(gha_pkg::OP_CREATE, $urandom_range(1023),
                                  $urandom_range(255)), r);
         end else if (roll < create_pct + 30) begin
            send_request(make_req(gha_pkg::OP_DESTROY, idx, ver), r);
         end else if (roll < 90) begin
            send_request(make_req(($urandom_range(3) == 0) ? 2'd3 : gha_pkg::OP_QUERY,
                                  idx, ver), r);
         end else begin
            send_request(make_req(2'($urandom_range(3)), $urandom_range(1023),
                                  $urandom_range(255)), r);
         end
      end
   endtask

   // Fill every slot, then check full creates, top index and reuse from full.
   task automatic test_table_full();
      gha_pkg::rsp_type r;
      gap_pct = 0;
      while (!(list_head == gha_pkg::LIST_EMPTY && slots_issued == gha_pkg::LIST_EMPTY)) begin
         send_request(make_req(gha_pkg::OP_CREATE, 0, 0), r);
      end
      send_request(make_req(gha_pkg::OP_CREATE, 1023, 255), r);
      send_request(make_req(gha_pkg::OP_CREATE, $urandom_range(1023),
                            $urandom_range(255)), r);
      send_request(make_req(gha_pkg::OP_QUERY, 1023, slot_gen[1023]), r);
      send_request(make_req(gha_pkg::OP_QUERY, 1023, slot_gen[1023] + 8'd1), r);
      send_request(make_req(gha_pkg::OP_DESTROY, 1023, slot_gen[1023]), r);
      send_request(make_req(gha_pkg::OP_DESTROY, 0, slot_gen[0]), r);
      send_request(make_req(gha_pkg::OP_CREATE, 0, 0), r);
      send_request(make_req(gha_pkg::OP_CREATE, 0, 0), r);
      send_request(make_req(gha_pkg::OP_CREATE, 0, 0), r);
      for (int n = 0; n < 40; n++) begin
         send_request(make_req(2'($urandom_range(3)), $urandom_range(1023),
                               $urandom_range(255)), r);
      end
   endtask

   initial begin
      reset        = 1'b1;
      start        = 1'b0;
      req_data     = '0;
      quiet_cycles = 0;
      mismatches   = 0;
      gap_pct      = 0;
      list_head    = gha_pkg::LIST_EMPTY;
      slots_issued = '0;
      live_handles = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_version_wrap();
      test_random_traffic();
      test_table_full();
      start <= 1'b0;

      // Let the last responses drain and settle, then report.
      while (pending_replies.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
